>>> hdl/assert_macros.svh
// Assertion macros shared by the checker files of the centered FIR core.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent at one edge implies consequent at the next edge.
`define CFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Antecedent implies consequent at the same edge.
`define CFIR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

`endif

>>> hdl/cfir_pkg.sv
// Shared constants, codes, state types and width helpers of the centered FIR core.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package cfir_pkg;

  // Default sizes and fixed formats
  localparam int MAX_TAPS    = 33;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_BITS    = 18;
  localparam int FRAC_BITS   = 16;   // taps are Q2.16
  localparam int CFG_BITS    = 5;
  localparam int INDEX_BITS  = 6;
  localparam int QUEUE_DEPTH = 2;

  // Request command codes
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // Front sequencer states
  typedef enum logic {
    F_IDLE,
    F_ISSUE
  } front_state_e;

  // Back MAC engine states
  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_OUT
  } back_state_e;

  // Bits to hold the values 0 .. n-1, at least one.
  function automatic int bits_for(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Largest usable half width for a given tap count.
  function automatic int half_max(input int taps);
    return (taps - 1) >> 1;
  endfunction

  // Width of one packed job: distance, half width, write pointer, last flag.
  function automatic int job_bits(input int taps);
    return 2 * bits_for(half_max(taps) + 1) + bits_for(taps) + 1;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on cfir_pkg for the address width helper.
`default_nettype none

module cfir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = cfir_pkg::bits_for(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/cfir_fifo.sv
// Small register FIFO used for the job queue and the result queue.
// Depends on cfir_pkg for the pointer width helper.
`default_nettype none

module cfir_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW   = cfir_pkg::bits_for(DEPTH),
  localparam int CW   = cfir_pkg::bits_for(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cfir_front.sv
// Front end: takes requests, loads taps, writes the sample window and issues
// one MAC job per output. Depends on cfir_pkg.
`default_nettype none

module cfir_front #(
  parameter int MAX_TAPS    = cfir_pkg::MAX_TAPS,
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS,
  parameter int TAP_BITS    = cfir_pkg::TAP_BITS,
  localparam int AW         = cfir_pkg::bits_for(MAX_TAPS),
  localparam int JOB_W      = cfir_pkg::job_bits(MAX_TAPS)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [cfir_pkg::CFG_BITS-1:0]        cfg_half_width_i,
  // request channel
  input  wire logic                                 push_i,
  output logic                                      full_o,
  input  wire logic                                 command_i,
  input  wire logic [cfir_pkg::INDEX_BITS-1:0]      tap_index_i,
  input  wire logic signed [TAP_BITS-1:0]           tap_value_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic                                 end_of_sequence_i,
  // back end status and job queue
  input  wire logic                                 back_busy_i,
  input  wire logic                                 job_full_i,
  input  wire logic                                 job_empty_i,
  output logic                                      job_push_o,
  output logic      [JOB_W-1:0]                     job_data_o,
  // sample window write
  output logic                                      win_we_o,
  output logic      [AW-1:0]                        win_waddr_o,
  output logic      [SAMPLE_BITS-1:0]               win_wdata_o,
  output logic      [MAX_TAPS-1:0]                  win_valid_o,
  // coefficient write
  output logic                                      coef_we_o,
  output logic      [AW-1:0]                        coef_waddr_o,
  output logic      [TAP_BITS-1:0]                  coef_wdata_o
);

  localparam int HALF_MAX = cfir_pkg::half_max(MAX_TAPS);
  localparam int HW       = cfir_pkg::bits_for(HALF_MAX + 1);
  localparam int SW       = cfir_pkg::bits_for(HALF_MAX + 2);

  typedef struct packed {
    logic [HW-1:0] lag;
    logic [HW-1:0] half;
    logic [AW-1:0] wptr;
    logic          last;
  } job_t;

  cfir_pkg::front_state_e f_state_q, f_state_d;

  logic [cfir_pkg::CFG_BITS-1:0] cfg_q, cfg_d;
  logic [AW-1:0]       wp_q, wp_d, wp_eff;
  logic [SW-1:0]       seen_q, seen_d, seen_eff;
  logic [MAX_TAPS-1:0] valid_q, valid_d, valid_eff;
  logic                clr_q, clr_d;
  logic [HW-1:0]       d_q, d_d, h_q, h_d, h_eff;
  logic                flush_q, flush_d;
  logic [SW:0]         seen_inc, seen_cap, seen_new;
  logic                in_ready, take, take_sample, take_load, job_needed, issue_done;
  job_t                job;

  // Handshake and classification
  assign in_ready    = (f_state_q == cfir_pkg::F_IDLE) && job_empty_i && !back_busy_i;
  assign take        = push_i && in_ready;
  assign take_sample = take && (command_i == cfir_pkg::CMD_SAMPLE);
  assign take_load   = take && (command_i == cfir_pkg::CMD_LOAD);
  assign issue_done  = !job_full_i && ((d_q == '0) || !flush_q);

  // Effective half width, sequence state with a pending clear folded in
  assign h_eff     = (int'(cfg_q) > HALF_MAX) ? HW'(HALF_MAX) : HW'(cfg_q);
  assign wp_eff    = clr_q ? '0 : wp_q;
  assign seen_eff  = clr_q ? '0 : seen_q;
  assign valid_eff = clr_q ? '0 : valid_q;
  assign seen_inc  = (SW + 1)'(seen_eff) + 1'b1;
  assign seen_cap  = (SW + 1)'(h_eff) + 1'b1;
  assign seen_new  = (seen_inc > seen_cap) ? seen_cap : seen_inc;
  assign job_needed = end_of_sequence_i || (seen_new == seen_cap);

  // Next state
  always_comb begin
    f_state_d = f_state_q;
    unique case (f_state_q)
      cfir_pkg::F_IDLE: begin
        if (take_sample && job_needed) begin
          f_state_d = cfir_pkg::F_ISSUE;
        end
      end
      cfir_pkg::F_ISSUE: begin
        if (issue_done) begin
          f_state_d = cfir_pkg::F_IDLE;
        end
      end
      default: f_state_d = cfir_pkg::F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    job.lag      = d_q;
    job.half     = h_q;
    job.wptr     = wp_q;
    job.last     = flush_q && (d_q == '0);
    job_data_o   = job;
    job_push_o   = (f_state_q == cfir_pkg::F_ISSUE) && !job_full_i;
    full_o       = !in_ready;
    cfg_ready_o  = 1'b1;
    win_we_o     = take_sample;
    win_waddr_o  = wp_eff;
    win_wdata_o  = sample_i;
    win_valid_o  = valid_q;
    coef_we_o    = take_load && (int'(tap_index_i) < MAX_TAPS);
    coef_waddr_o = AW'(tap_index_i);
    coef_wdata_o = tap_value_i;
  end

  // Sequence bookkeeping
  always_comb begin
    cfg_d   = cfg_q;
    wp_d    = wp_q;
    seen_d  = seen_q;
    valid_d = valid_q;
    clr_d   = clr_q;
    d_d     = d_q;
    h_d     = h_q;
    flush_d = flush_q;
    if (cfg_valid_i) begin
      cfg_d = cfg_half_width_i;
    end
    if (take_sample) begin
      valid_d         = valid_eff;
      valid_d[wp_eff] = 1'b1;
      wp_d    = (wp_eff == AW'(MAX_TAPS - 1)) ? '0 : wp_eff + 1'b1;
      seen_d  = SW'(seen_new);
      clr_d   = 1'b0;
      h_d     = h_eff;
      flush_d = end_of_sequence_i;
      d_d     = end_of_sequence_i ? HW'(seen_new - 1'b1) : h_eff;
    end
    // walk the flush distances down to zero
    if (job_push_o) begin
      if (issue_done) begin
        clr_d = flush_q;
      end else begin
        d_d = d_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_state_q <= cfir_pkg::F_IDLE;
      cfg_q     <= '0;
      wp_q      <= '0;
      seen_q    <= '0;
      valid_q   <= '0;
      clr_q     <= 1'b0;
      d_q       <= '0;
      h_q       <= '0;
      flush_q   <= 1'b0;
    end else begin
      f_state_q <= f_state_d;
      cfg_q     <= cfg_d;
      wp_q      <= wp_d;
      seen_q    <= seen_d;
      valid_q   <= valid_d;
      clr_q     <= clr_d;
      d_q       <= d_d;
      h_q       <= h_d;
      flush_q   <= flush_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cfir_back.sv
// Back end: one shared multiply-accumulate walks the taps of each job, then
// rounds and saturates the sum. Depends on cfir_pkg.
`default_nettype none

module cfir_back #(
  parameter int MAX_TAPS    = cfir_pkg::MAX_TAPS,
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS,
  parameter int TAP_BITS    = cfir_pkg::TAP_BITS,
  localparam int AW         = cfir_pkg::bits_for(MAX_TAPS),
  localparam int JOB_W      = cfir_pkg::job_bits(MAX_TAPS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // job queue
  input  wire logic                   job_empty_i,
  output logic                        job_pop_o,
  input  wire logic [JOB_W-1:0]       job_data_i,
  // window and coefficient reads
  input  wire logic [MAX_TAPS-1:0]    win_valid_i,
  output logic      [AW-1:0]          win_raddr_o,
  input  wire logic [SAMPLE_BITS-1:0] win_rdata_i,
  output logic      [AW-1:0]          coef_raddr_o,
  input  wire logic [TAP_BITS-1:0]    coef_rdata_i,
  // status and result queue
  output logic                        busy_o,
  input  wire logic                   res_full_i,
  output logic                        res_push_o,
  output logic      [SAMPLE_BITS:0]   res_data_o
);

  localparam int HALF_MAX = cfir_pkg::half_max(MAX_TAPS);
  localparam int HW       = cfir_pkg::bits_for(HALF_MAX + 1);
  localparam int PW       = AW + 1;
  localparam int FRAC     = cfir_pkg::FRAC_BITS;
  localparam int PROD_W   = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_W    = PROD_W + cfir_pkg::bits_for(MAX_TAPS + 1);
  localparam int QW       = ACC_W + 1 - FRAC;
  localparam int EW       = (QW > SAMPLE_BITS) ? QW : SAMPLE_BITS + 1;

  localparam logic signed [ACC_W:0] RND_BIAS =
    {{(ACC_W + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
  localparam logic signed [EW-1:0] SAT_HI =
    {{(EW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic [HW-1:0] lag;
    logic [HW-1:0] half;
    logic [AW-1:0] wptr;
    logic          last;
  } job_t;

  cfir_pkg::back_state_e b_state_q, b_state_d;

  job_t                      job;
  logic [AW-1:0]             addr_q, addr_d, j_q, j_d, n_q, n_d;
  logic                      last_q, last_d;
  logic                      ok_q, s1_v_q, s2_v_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [TAP_BITS-1:0]    cof;
  logic [HW:0]               span;
  logic [PW-1:0]             base, first;
  logic                      start, issue;
  logic signed [ACC_W:0]     rnd, shr;
  logic signed [EW-1:0]      q;
  logic [SAMPLE_BITS-1:0]    filt;

  assign job   = job_t'(job_data_i);
  assign start = (b_state_q == cfir_pkg::B_IDLE) && !job_empty_i;
  assign issue = (b_state_q == cfir_pkg::B_RUN);

  // First window address: oldest sample that meets tap zero
  assign span  = (HW + 1)'(job.lag) + (HW + 1)'(job.half);
  assign base  = PW'(job.wptr) + PW'(MAX_TAPS - 1) - PW'(span);
  assign first = (base >= PW'(MAX_TAPS)) ? base - PW'(MAX_TAPS) : base;

  // Next state
  always_comb begin
    b_state_d = b_state_q;
    unique case (b_state_q)
      cfir_pkg::B_IDLE:  if (!job_empty_i) b_state_d = cfir_pkg::B_RUN;
      cfir_pkg::B_RUN:   if (j_q == n_q) b_state_d = cfir_pkg::B_DRAIN;
      cfir_pkg::B_DRAIN: if (!s1_v_q && !s2_v_q) b_state_d = cfir_pkg::B_OUT;
      cfir_pkg::B_OUT:   if (!res_full_i) b_state_d = cfir_pkg::B_IDLE;
      default:           b_state_d = cfir_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    job_pop_o    = start;
    busy_o       = (b_state_q != cfir_pkg::B_IDLE);
    res_push_o   = (b_state_q == cfir_pkg::B_OUT) && !res_full_i;
    res_data_o   = {last_q, filt};
    win_raddr_o  = addr_q;
    coef_raddr_o = j_q;
  end

  // Tap walk counters
  always_comb begin
    addr_d = addr_q;
    j_d    = j_q;
    n_d    = n_q;
    last_d = last_q;
    if (start) begin
      addr_d = AW'(first);
      j_d    = '0;
      n_d    = AW'(span);
      last_d = job.last;
    end else if (issue) begin
      addr_d = (addr_q == AW'(MAX_TAPS - 1)) ? '0 : addr_q + 1'b1;
      j_d    = j_q + 1'b1;
    end
  end

  // Multiply on registered RAM data; entries never written read as zero
  always_comb begin
    smp    = ok_q ? $signed(win_rdata_i) : '0;
    cof    = $signed(coef_rdata_i);
    prod_d = smp * cof;
    acc_d  = acc_q;
    if (start) begin
      acc_d = '0;
    end else if (s2_v_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // Round to nearest, ties up, then saturate
  always_comb begin
    rnd  = (ACC_W + 1)'(acc_q) + RND_BIAS;
    shr  = rnd >>> FRAC;
    q    = EW'(shr);
    if (q > SAT_HI) begin
      filt = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      filt = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      filt = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_state_q <= cfir_pkg::B_IDLE;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      addr_q    <= '0;
      j_q       <= '0;
      n_q       <= '0;
      last_q    <= 1'b0;
    end else begin
      b_state_q <= b_state_d;
      s1_v_q    <= issue;
      s2_v_q    <= s1_v_q;
      addr_q    <= addr_d;
      j_q       <= j_d;
      n_q       <= n_d;
      last_q    <= last_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ok_q   <= win_valid_i[addr_q];
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

endmodule

`default_nettype wire

>>> hdl/centered_fir_convolution_core.sv
// Top level of the centered, zero-padded, same-length FIR core.
// Depends on cfir_pkg, cfir_front, cfir_back, cfir_fifo and cfir_ram.
//
//  channel   handshake              payload
//  ------    ---------------------  ---------------------------------------------
//  config    cfg_valid / cfg_ready  cfg_half_width_i
//  request   push / full            command_i tap_index_i tap_value_i sample_i
//                                   end_of_sequence_i
//  result    empty / pop            filtered_o last_output_o
//
// Loads and samples that produce no output leave the request port open. The output lying d
// samples behind the newest is computed by the single MAC walking d + h + 1 taps
// from the window and coefficient RAMs; a sample with one output walks 2h + 1 taps,
// and a flush walks the taps of each of its outputs in turn.
// Reset clears the window valid bits at once; no clearing pass is needed.
// A result waits on the ports until popped; the MAC holds when the result queue fills.
`default_nettype none

module centered_fir_convolution_core #(
  parameter int MAX_TAPS    = cfir_pkg::MAX_TAPS,
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS,
  parameter int TAP_BITS    = cfir_pkg::TAP_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cfir_pkg::CFG_BITS-1:0]   cfg_half_width_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            command_i,
  input  wire logic [cfir_pkg::INDEX_BITS-1:0] tap_index_i,
  input  wire logic signed [TAP_BITS-1:0]      tap_value_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  wire logic                            end_of_sequence_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic signed [SAMPLE_BITS-1:0]        filtered_o,
  output logic                                 last_output_o
);

  localparam int AW    = cfir_pkg::bits_for(MAX_TAPS);
  localparam int JOB_W = cfir_pkg::job_bits(MAX_TAPS);

  logic                   back_busy;
  logic                   job_full, job_empty, job_push, job_pop;
  logic [JOB_W-1:0]       job_wdata, job_rdata;
  logic                   win_we, coef_we;
  logic [AW-1:0]          win_waddr, win_raddr, coef_waddr, coef_raddr;
  logic [SAMPLE_BITS-1:0] win_wdata, win_rdata;
  logic [TAP_BITS-1:0]    coef_wdata, coef_rdata;
  logic [MAX_TAPS-1:0]    win_valid;
  logic                   res_full, res_push;
  logic [SAMPLE_BITS:0]   res_wdata, res_rdata;

  // Request intake and job issue
  cfir_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAP_BITS    (TAP_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_half_width_i  (cfg_half_width_i),
    .push_i            (push),
    .full_o            (full),
    .command_i         (command_i),
    .tap_index_i       (tap_index_i),
    .tap_value_i       (tap_value_i),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .back_busy_i       (back_busy),
    .job_full_i        (job_full),
    .job_empty_i       (job_empty),
    .job_push_o        (job_push),
    .job_data_o        (job_wdata),
    .win_we_o          (win_we),
    .win_waddr_o       (win_waddr),
    .win_wdata_o       (win_wdata),
    .win_valid_o       (win_valid),
    .coef_we_o         (coef_we),
    .coef_waddr_o      (coef_waddr),
    .coef_wdata_o      (coef_wdata)
  );

  // Job queue between front and back
  cfir_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (cfir_pkg::QUEUE_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_rdata),
    .empty_o (job_empty)
  );

  // Sample window and coefficient store
  cfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  cfir_ram #(
    .WIDTH (TAP_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Shared MAC engine
  cfir_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAP_BITS    (TAP_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (job_empty),
    .job_pop_o    (job_pop),
    .job_data_i   (job_rdata),
    .win_valid_i  (win_valid),
    .win_raddr_o  (win_raddr),
    .win_rdata_i  (win_rdata),
    .coef_raddr_o (coef_raddr),
    .coef_rdata_i (coef_rdata),
    .busy_o       (back_busy),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_data_o   (res_wdata)
  );

  // Result queue toward the consumer
  cfir_fifo #(
    .WIDTH (SAMPLE_BITS + 1),
    .DEPTH (cfir_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rdata),
    .empty_o (empty)
  );

  assign last_output_o = res_rdata[SAMPLE_BITS];
  assign filtered_o    = res_rdata[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

>>> hdl/cfir_checker.sv
// Port-level checks of the centered FIR core, bound to the top level.
// Depends on cfir_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cfir_checker #(
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   push_i,
  input wire logic                   full_i,
  input wire logic                   command_i,
  input wire logic                   end_of_sequence_i,
  input wire logic                   empty_i,
  input wire logic                   pop_i,
  input wire logic [SAMPLE_BITS-1:0] filtered_i,
  input wire logic                   last_output_i
);

  // An open request port means nothing is in flight: no result can show next
  `CFIR_ASSERT_NEXT(a_idle_no_result, clk_i, rst_ni, empty_i && !full_i, empty_i)

  // A flushing sample always blocks the next request while outputs are issued
  `CFIR_ASSERT_NEXT(a_flush_blocks, clk_i, rst_ni,
    push_i && !full_i && (command_i == cfir_pkg::CMD_SAMPLE) && end_of_sequence_i, full_i)

  // A waiting result holds until popped
  `CFIR_ASSERT_NEXT(a_result_held, clk_i, rst_ni, !empty_i && !pop_i,
    !empty_i && $stable(filtered_i) && $stable(last_output_i))

endmodule

bind centered_fir_convolution_core cfir_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cfir_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .push_i            (push),
  .full_i            (full),
  .command_i         (command_i),
  .end_of_sequence_i (end_of_sequence_i),
  .empty_i           (empty),
  .pop_i             (pop),
  .filtered_i        (filtered_o),
  .last_output_i     (last_output_o)
);

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for centered_fir_convolution_core: tap loads and sample
// sequences go through a queue-style driver, and a scoreboard predicts every output.
// Depends on cfir_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_TAPS        = cfir_pkg::MAX_TAPS;
  localparam int SAMPLE_BITS     = cfir_pkg::SAMPLE_BITS;
  localparam int TAP_BITS        = cfir_pkg::TAP_BITS;
  localparam int FRAC_BITS       = cfir_pkg::FRAC_BITS;
  localparam int CFG_BITS        = cfir_pkg::CFG_BITS;
  localparam int INDEX_BITS      = cfir_pkg::INDEX_BITS;
  localparam int HALF_MAX        = (MAX_TAPS - 1) / 2;
  localparam int PHASE_ITEMS     = 36;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int PRINT_LIMIT     = 40;
  localparam longint OUT_MAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN     = -OUT_MAX - 1;

  localparam logic signed [TAP_BITS-1:0]    TAP_UNITY  = 18'sh10000;
  localparam logic signed [TAP_BITS-1:0]    TAP_HALF   = 18'sh08000;
  localparam logic signed [TAP_BITS-1:0]    TAP_TOP    = 18'sh1ffff;
  localparam logic signed [TAP_BITS-1:0]    TAP_BOTTOM = 18'sh20000;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_TOP    = 16'sh7fff;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_BOTTOM = 16'sh8000;

  typedef struct {
    cfir_pkg::cmd_e                command;
    logic [INDEX_BITS-1:0]         tap_index;
    logic signed [TAP_BITS-1:0]    tap_value;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          eos;
  } request_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          last;
  } fir_output_t;

  // DUT connections; every input that the bench drives is known from time zero
  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          cfg_valid         = 1'b0;
  logic                          cfg_ready;
  logic [CFG_BITS-1:0]           cfg_half_width_i  = '0;
  logic                          push              = 1'b0;
  logic                          full;
  logic                          command_i         = 1'b0;
  logic [INDEX_BITS-1:0]         tap_index_i       = '0;
  logic signed [TAP_BITS-1:0]    tap_value_i       = '0;
  logic signed [SAMPLE_BITS-1:0] sample_i          = '0;
  logic                          end_of_sequence_i = 1'b0;
  logic                          empty;
  logic                          pop               = 1'b0;
  logic signed [SAMPLE_BITS-1:0] filtered_o;
  logic                          last_output_o;

  // Filter model state
  logic signed [SAMPLE_BITS-1:0] win_q  [MAX_TAPS] = '{default: '0};
  logic signed [TAP_BITS-1:0]    coef_q [MAX_TAPS] = '{default: '0};
  int                            wr_ptr     = 0;
  int                            seen_cnt   = 0;
  logic [CFG_BITS-1:0]           model_half = '0;

  // Request and output queues, bookkeeping
  request_t    pending_requests[$];
  fir_output_t due_outputs[$];
  request_t    offer;
  logic        tap_written [MAX_TAPS] = '{default: 1'b0};
  int          stim_count    = 0;
  int          seq_left      = 0;
  int          error_count   = 0;
  int          out_count     = 0;
  int          cycle_count   = 0;
  int          burst_left    = 8;
  int          gap_left      = 0;
  int          hold_left     = 0;
  int unsigned pattern_cnt   = 0;
  int          pop_mode      = 0;
  logic        hold_off_req  = 1'b0;
  logic        hold_off_done = 1'b0;

  centered_fir_convolution_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_half_width_i  (cfg_half_width_i),
    .push              (push),
    .full              (full),
    .command_i         (command_i),
    .tap_index_i       (tap_index_i),
    .tap_value_i       (tap_value_i),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .empty             (empty),
    .pop               (pop),
    .filtered_o        (filtered_o),
    .last_output_o     (last_output_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // One output point: window samples d behind the newest, centered kernel of half width h
  function automatic logic signed [SAMPLE_BITS-1:0] convolve_point(input int d, input int h);
    longint acc;
    longint rnd;
    int     k;
    int     idx;
    acc = 0;
    for (int j = 0; j <= 2 * h && j <= d + h; j++) begin
      k   = d + h - j;
      idx = (wr_ptr + MAX_TAPS - 1 - k) % MAX_TAPS;
      acc += longint'(win_q[idx]) * longint'(coef_q[j]);
    end
    // round half up, then saturate
    rnd = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rnd > OUT_MAX) rnd = OUT_MAX;
    if (rnd < OUT_MIN) rnd = OUT_MIN;
    return SAMPLE_BITS'(rnd);
  endfunction

  // Update the filter model with one accepted request and queue its outputs
  task automatic advance_filter(input request_t rq);
    int          he;
    int          top;
    fir_output_t res;
    if (rq.command == cfir_pkg::CMD_LOAD) begin
      if (rq.tap_index < MAX_TAPS) coef_q[rq.tap_index] = rq.tap_value;
    end else begin
      he = (model_half > HALF_MAX) ? HALF_MAX : int'(model_half);
      win_q[wr_ptr] = rq.sample;
      wr_ptr = (wr_ptr + 1) % MAX_TAPS;
      if (seen_cnt < he + 1) seen_cnt++;
      if (seen_cnt > he + 1) seen_cnt = he + 1;
      if (rq.eos) begin
        // flush: every pending output, newest last, final one flagged
        top = (seen_cnt - 1 > he) ? he : seen_cnt - 1;
        for (int d = top; d >= 0; d--) begin
          res.filtered = convolve_point(d, he);
          res.last     = (d == 0);
          due_outputs.push_back(res);
        end
        win_q    = '{default: '0};
        wr_ptr   = 0;
        seen_cnt = 0;
      end else if (seen_cnt >= he + 1) begin
        res.filtered = convolve_point(he, he);
        res.last     = 1'b0;
        due_outputs.push_back(res);
      end
    end
  endtask

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) advance_filter(offer);
      if (push && full) begin
        // hold the request until taken
      end else if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        offer = pending_requests.pop_front();
        push              <= 1'b1;
        command_i         <= offer.command;
        tap_index_i       <= offer.tap_index;
        tap_value_i       <= offer.tap_value;
        sample_i          <= offer.sample;
        end_of_sequence_i <= offer.eos;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Output monitor and pop pattern, with one long hold-off to back up the core
  always @(posedge clk_i or negedge rst_ni) begin
    fir_output_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_outputs.size() == 0) begin
          report_mismatch($sformatf("output %0d not expected: filtered %0d last %0b",
                                    out_count, filtered_o, last_output_o));
        end else begin
          want = due_outputs.pop_front();
          if (filtered_o !== want.filtered)
            report_mismatch($sformatf("output %0d: filtered %0d, want %0d",
                                      out_count, filtered_o, want.filtered));
          if (last_output_o !== want.last)
            report_mismatch($sformatf("output %0d: last_output %0b, want %0b",
                                      out_count, last_output_o, want.last));
        end
        out_count++;
      end
      pattern_cnt++;
      if (pattern_cnt % 64 == 0) pop_mode = $urandom_range(0, 3);
      if (hold_off_req && !hold_off_done) begin
        hold_left     = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= pattern_cnt[3];
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("centered_fir_convolution_core verification failed");
      $finish;
    end
  end

  function automatic logic signed [TAP_BITS-1:0] pick_tap();
    case ($urandom_range(0, 9)) inside
      0:       return TAP_TOP;
      1:       return TAP_BOTTOM;
      [2:3]:   return TAP_BITS'($urandom);
      default: return TAP_BITS'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_TOP;
      1:       return SMP_BOTTOM;
      2:       return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic add_load(input int idx, input logic signed [TAP_BITS-1:0] val);
    request_t rq;
    rq.command   = cfir_pkg::CMD_LOAD;
    rq.tap_index = INDEX_BITS'(idx);
    rq.tap_value = val;
    rq.sample    = SAMPLE_BITS'($urandom);
    rq.eos       = 1'($urandom_range(0, 1));   // don't care on a load
    if (idx < MAX_TAPS) begin
      tap_written[idx] = 1'b1;
      stim_count++;
    end
    pending_requests.push_back(rq);
  endtask

  task automatic add_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic eos);
    request_t rq;
    rq.command   = cfir_pkg::CMD_SAMPLE;
    rq.tap_index = INDEX_BITS'($urandom);
    rq.tap_value = TAP_BITS'($urandom);
    rq.sample    = smp;
    rq.eos       = eos;
    stim_count++;
    pending_requests.push_back(rq);
  endtask

  // Drain: nothing queued, nothing offered, no output outstanding, then settle
  task automatic wait_idle();
    while (pending_requests.size() != 0 || push || due_outputs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_half_width(input int value);
    cfg_valid        <= 1'b1;
    cfg_half_width_i <= CFG_BITS'(value);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid  <= 1'b0;
    model_half = CFG_BITS'(value);
  endtask

  // Stimulus
  initial begin
    int half_plan[10];
    int he;
    half_plan = '{16, 31, 2, 0, 17, 7, 1, 20, 11, 4};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // h = 0: unity pass-through, then both saturation directions
    write_half_width(0);
    add_load(0, TAP_UNITY);
    add_sample(SMP_TOP, 1'b0);
    add_sample(SMP_BOTTOM, 1'b0);
    add_sample(16'sd1234, 1'b1);
    add_load(0, TAP_TOP);
    add_sample(SMP_TOP, 1'b1);
    add_sample(SMP_BOTTOM, 1'b1);
    add_load(0, TAP_BOTTOM);
    add_sample(SMP_BOTTOM, 1'b1);
    add_sample(SMP_TOP, 1'b1);
    wait_idle();

    // h = 1: half taps for rounding ties, out-of-range loads, short sequence
    write_half_width(1);
    add_load(1, TAP_HALF);
    add_load(2, -18'sh04000);
    add_load(0, TAP_UNITY);
    add_load(63, TAP_TOP);
    add_load(33, TAP_BOTTOM);
    add_sample(16'sd100, 1'b1);
    add_sample(SMP_TOP, 1'b0);
    add_sample(SMP_BOTTOM, 1'b0);
    add_sample(16'sd5, 1'b0);
    add_sample(-16'sd7, 1'b1);

    // Random phases; a sequence may run across a half-width change
    foreach (half_plan[p]) begin
      wait_idle();
      write_half_width(half_plan[p]);
      he = (half_plan[p] > HALF_MAX) ? HALF_MAX : half_plan[p];
      for (int j = 0; j <= 2 * he; j++)
        if (!tap_written[j]) add_load(j, pick_tap());
      stim_count = 0;
      while (stim_count < PHASE_ITEMS) begin
        if (seq_left == 0)
          seq_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, he + 1)
                                                 : $urandom_range(he + 1, he + 30);
        if ($urandom_range(0, 99) < 8) begin
          add_load($urandom_range(0, 63), pick_tap());
        end else begin
          seq_left--;
          add_sample(pick_sample(), seq_left == 0 && $urandom_range(0, 9) != 0);
        end
      end
      if (p == 0) hold_off_req <= 1'b1;
    end

    wait_idle();
    if (due_outputs.size() != 0)
      report_mismatch($sformatf("%0d outputs never arrived", due_outputs.size()));
    if (error_count == 0) begin
      $display("centered_fir_convolution_core verification clean");
    end else begin
      $display("centered_fir_convolution_core verification failed");
    end
    $finish;
  end

endmodule
